>>> src/dics_pkg.sv
// Shared types and constants for the discrete inverse-CDF sampler.
// No dependencies; every other file imports this package.
`default_nettype none

package dics_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
    localparam int COUNT_BITS  = ADDR_BITS + 1;
    localparam int ENERGY_BITS = 24;
    localparam int CUM_BITS    = 24;
    localparam int WEIGHT_BITS = 16;
    localparam int RAND_BITS   = 32;
    localparam int PROD_BITS   = RAND_BITS + CUM_BITS;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_SAMPLE = 2'd2
    } command_t;

    typedef enum logic [1:0] {
        STAT_OK          = 2'd0,
        STAT_EMPTY       = 2'd1,
        STAT_FULL        = 2'd2,
        STAT_ZERO_ENERGY = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        DP_NONE,
        DP_CLEAR,
        DP_APPEND,
        DP_REPORT,
        DP_INIT,
        DP_MUL,
        DP_STEP,
        DP_FETCH
    } dp_op_t;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_MUL,
        CTL_SEARCH,
        CTL_FETCH
    } ctl_state_t;

    // Controller to datapath
    typedef struct packed {
        dp_op_t  op;
        status_t report_status;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic table_empty;
        logic table_full;
        logic energy_zero;
        logic search_done;
        logic out_free;
    } dp_flags_t;

endpackage

`default_nettype wire

>>> src/dics_req_if.sv
// Request channel of the sampler: valid/ready plus one command word.
// Depends on dics_pkg for field widths.
`default_nettype none

interface dics_req_if;
    import dics_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [1:0]             command;
    logic [ENERGY_BITS-1:0] energy_code;
    logic [WEIGHT_BITS-1:0] entry_weight;
    logic [RAND_BITS-1:0]   random_fraction;

    modport source (
        output valid, command, energy_code, entry_weight, random_fraction,
        input  ready
    );

    modport sink (
        input  valid, command, energy_code, entry_weight, random_fraction,
        output ready
    );
endinterface

`default_nettype wire

>>> src/dics_rsp_if.sv
// Result channel of the sampler: valid/ready plus one result word.
// Depends on dics_pkg for field widths.
`default_nettype none

interface dics_rsp_if;
    import dics_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [ENERGY_BITS-1:0] sampled_energy;
    logic [1:0]             status;
    logic [COUNT_BITS-1:0]  entry_count;

    modport source (
        output valid, sampled_energy, status, entry_count,
        input  ready
    );

    modport sink (
        input  valid, sampled_energy, status, entry_count,
        output ready
    );
endinterface

`default_nettype wire

>>> src/dics_datapath.sv
// Datapath: energy and cumulative-weight RAMs, count/total registers,
// target multiplier, binary-search bounds and the result register. Uses dics_pkg.
`default_nettype none

module dics_datapath
    import dics_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire dp_cmd_t                cmd,
    input  wire logic [ENERGY_BITS-1:0] energy_code,
    input  wire logic [WEIGHT_BITS-1:0] entry_weight,
    input  wire logic [RAND_BITS-1:0]   random_fraction,
    output dp_flags_t                   flags,
    input  wire logic                   out_ready,
    output logic                        out_valid,
    output logic [ENERGY_BITS-1:0]      sampled_energy,
    output logic [1:0]                  status,
    output logic [COUNT_BITS-1:0]       entry_count
);

    logic [ENERGY_BITS-1:0] energy_mem [TABLE_DEPTH];
    logic [CUM_BITS-1:0]    cum_mem    [TABLE_DEPTH];

    logic [ENERGY_BITS-1:0] energy_rd_reg;
    logic [CUM_BITS-1:0]    cum_rd_reg;
    logic [ADDR_BITS-1:0]   rd_addr;

    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic [CUM_BITS-1:0]    total_reg, total_next;
    logic [CUM_BITS:0]      total_sum;

    logic [RAND_BITS-1:0]   rnd_reg;
    logic [PROD_BITS-1:0]   prod_reg;
    logic [CUM_BITS-1:0]    target;

    logic [COUNT_BITS-1:0]  lo_reg, hi_reg, lo_n, hi_n, last_idx, pick_idx;
    logic [ADDR_BITS-1:0]   mid_reg, mid_n;
    logic [COUNT_BITS:0]    mid_sum;

    logic                   out_valid_reg;
    logic [ENERGY_BITS-1:0] energy_out_reg;
    status_t                status_out_reg;
    logic [COUNT_BITS-1:0]  count_out_reg;

    // Table bookkeeping
    assign total_sum = {1'b0, total_reg} + (CUM_BITS + 1)'(entry_weight);

    always_comb
    begin
        count_next = count_reg;
        total_next = total_reg;
        case (cmd.op)
            DP_CLEAR:
            begin
                count_next = '0;
                total_next = '0;
            end
            DP_APPEND:
            begin
                count_next = count_reg + COUNT_BITS'(1);
                total_next = total_sum[CUM_BITS] ? '1 : total_sum[CUM_BITS-1:0];
            end
            default:
            begin
                count_next = count_reg;
                total_next = total_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            total_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            total_reg <= total_next;
        end
    end

    // Search step: narrow [lo, hi) around the registered cumulative word
    assign target   = prod_reg[PROD_BITS-1:RAND_BITS];
    assign lo_n     = (cum_rd_reg > target) ? lo_reg : COUNT_BITS'(mid_reg) + COUNT_BITS'(1);
    assign hi_n     = (cum_rd_reg > target) ? COUNT_BITS'(mid_reg) : hi_reg;
    assign mid_sum  = {1'b0, lo_n} + {1'b0, hi_n};
    assign mid_n    = mid_sum[ADDR_BITS:1];
    assign last_idx = count_reg - COUNT_BITS'(1);
    assign pick_idx = (lo_n >= count_reg) ? last_idx : lo_n;

    always_comb
    begin
        case (cmd.op)
            DP_INIT:  rd_addr = count_reg[COUNT_BITS-1:1];
            DP_STEP:  rd_addr = flags.search_done ? pick_idx[ADDR_BITS-1:0] : mid_n;
            default:  rd_addr = mid_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_APPEND)
        begin
            energy_mem[count_reg[ADDR_BITS-1:0]] <= energy_code;
            cum_mem[count_reg[ADDR_BITS-1:0]]    <= total_next;
        end
        energy_rd_reg <= energy_mem[rd_addr];
        cum_rd_reg    <= cum_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_INIT:
            begin
                rnd_reg <= random_fraction;
                lo_reg  <= '0;
                hi_reg  <= count_reg;
                mid_reg <= count_reg[COUNT_BITS-1:1];
            end
            DP_MUL:
            begin
                prod_reg <= PROD_BITS'(rnd_reg) * PROD_BITS'(total_reg);
            end
            DP_STEP:
            begin
                lo_reg  <= lo_n;
                hi_reg  <= hi_n;
                mid_reg <= mid_n;
            end
            default:
            begin
                mid_reg <= mid_reg;
            end
        endcase
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == DP_CLEAR || cmd.op == DP_APPEND ||
                 cmd.op == DP_REPORT || cmd.op == DP_FETCH)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_CLEAR, DP_APPEND:
            begin
                energy_out_reg <= '0;
                status_out_reg <= STAT_OK;
                count_out_reg  <= count_next;
            end
            DP_REPORT:
            begin
                energy_out_reg <= '0;
                status_out_reg <= cmd.report_status;
                count_out_reg  <= count_reg;
            end
            DP_FETCH:
            begin
                energy_out_reg <= energy_rd_reg;
                status_out_reg <= STAT_OK;
                count_out_reg  <= count_reg;
            end
            default:
            begin
                count_out_reg <= count_out_reg;
            end
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign sampled_energy = energy_out_reg;
    assign status         = status_out_reg;
    assign entry_count    = count_out_reg;

    assign flags.table_empty = (count_reg == '0) || (total_reg == '0);
    assign flags.table_full  = (count_reg >= COUNT_BITS'(TABLE_DEPTH));
    assign flags.energy_zero = (energy_code == '0);
    assign flags.search_done = (lo_n >= hi_n);
    assign flags.out_free    = !out_valid_reg || out_ready;

endmodule

`default_nettype wire

>>> src/dics_controller.sv
// Controller: sequences each command word through the datapath.
// Uses dics_pkg for the state, command and datapath op types.
`default_nettype none

module dics_controller
    import dics_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    input  wire logic [1:0] req_command,
    output logic            req_ready,
    input  wire dp_flags_t  flags,
    output dp_cmd_t         cmd
);

    ctl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        req_ready         = 1'b0;
        cmd.op            = DP_NONE;
        cmd.report_status = STAT_OK;
        case (state_reg)
            CTL_IDLE:
            begin
                req_ready = flags.out_free;
                if (req_valid && flags.out_free)
                begin
                    case (req_command)
                        CMD_CLEAR:
                        begin
                            cmd.op = DP_CLEAR;
                        end
                        CMD_APPEND:
                        begin
                            if (flags.energy_zero)
                            begin
                                cmd.op            = DP_REPORT;
                                cmd.report_status = STAT_ZERO_ENERGY;
                            end
                            else if (flags.table_full)
                            begin
                                cmd.op            = DP_REPORT;
                                cmd.report_status = STAT_FULL;
                            end
                            else
                            begin
                                cmd.op = DP_APPEND;
                            end
                        end
                        CMD_SAMPLE:
                        begin
                            if (flags.table_empty)
                            begin
                                cmd.op            = DP_REPORT;
                                cmd.report_status = STAT_EMPTY;
                            end
                            else
                            begin
                                cmd.op     = DP_INIT;
                                state_next = CTL_MUL;
                            end
                        end
                        default:
                        begin
                            cmd.op = DP_REPORT;
                        end
                    endcase
                end
            end
            CTL_MUL:
            begin
                cmd.op     = DP_MUL;
                state_next = CTL_SEARCH;
            end
            CTL_SEARCH:
            begin
                cmd.op = DP_STEP;
                if (flags.search_done)
                begin
                    state_next = CTL_FETCH;
                end
            end
            CTL_FETCH:
            begin
                cmd.op     = DP_FETCH;
                state_next = CTL_IDLE;
            end
            default:
            begin
                state_next = CTL_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/discrete_inverse_cdf_sampler_core.sv
// Top level of the discrete inverse-CDF sampler: controller plus datapath.
// Depends on dics_pkg, dics_req_if, dics_rsp_if, dics_controller, dics_datapath.
//
// Each request word carries one command: clear the table, append an
// (energy, weight) entry, or draw a sample. Every command returns exactly one
// result word with the chosen energy (zero unless a draw succeeded), a status
// code and the number of entries held afterward. Clear, append, an unused
// command code and a rejected draw finish in the accept cycle; their result is
// visible the next cycle. A draw makes at most k = ceil(log2(n + 1)) search
// compares for n stored entries. It first starts the first cumulative RAM
// read, then does the 32 x 24 target multiply, then makes one compare per
// halving of the search range (the next RAM read address is chosen from that
// compare in the same cycle), and last reads the chosen energy. One command
// is in flight at a time; the request side stays ready while a result word is
// being taken in the same cycle. Append rejects a zero energy first, then a
// full table; the weight total saturates at 2^24-1. No clearing pass is needed
// after reset: only entries below the stored count are ever read.
`default_nettype none

module discrete_inverse_cdf_sampler_core
    import dics_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    dics_req_if.sink  request,
    dics_rsp_if.source result
);

    dp_cmd_t   dp_cmd;
    dp_flags_t dp_flags;
    logic      req_ready;

    assign request.ready = req_ready;

    dics_controller u_ctl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (request.valid),
        .req_command (request.command),
        .req_ready   (req_ready),
        .flags       (dp_flags),
        .cmd         (dp_cmd)
    );

    dics_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (dp_cmd),
        .energy_code     (request.energy_code),
        .entry_weight    (request.entry_weight),
        .random_fraction (request.random_fraction),
        .flags           (dp_flags),
        .out_ready       (result.ready),
        .out_valid       (result.valid),
        .sampled_energy  (result.sampled_energy),
        .status          (result.status),
        .entry_count     (result.entry_count)
    );

    // Never take a word while a stalled result would be overwritten.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && req_ready) |-> (!result.valid || result.ready))
        else $error("request accepted while result word stalled");

    // Held entries never exceed the table depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.entry_count <= COUNT_BITS'(TABLE_DEPTH)))
        else $error("entry count beyond table depth");

    // A nonzero energy only comes from a successful draw.
    a_energy_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.sampled_energy != '0) |-> (result.status == STAT_OK))
        else $error("energy returned with error status");

    // The energy fetch follows the last search step.
    a_fetch_after_step: assert property (@(posedge clk) disable iff (!rst_n)
        (dp_cmd.op == DP_FETCH) |-> ($past(dp_cmd.op) == DP_STEP))
        else $error("energy fetch without finished search");

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for discrete_inverse_cdf_sampler_core.
// Depends on dics_pkg, dics_req_if, dics_rsp_if and the sampler RTL.
`timescale 1ns / 1ps

module testbench
    import dics_pkg::*;
();

    // Command code 3 has no member in command_t; the block must treat it as a no-op.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int WORDS_PER_PHASE = 510;
    localparam int LONG_HOLD       = 300;   // result-side hold-off, in cycles
    localparam int STALL_LIMIT     = 2000;  // cycles with no word moved on either side
    localparam int SETTLE_CYCLES   = 24;    // extra wait after draining, before the final check

    typedef struct packed {
        logic [1:0]             cmd;
        logic [ENERGY_BITS-1:0] energy;
        logic [WEIGHT_BITS-1:0] weight;
        logic [RAND_BITS-1:0]   fraction;
    } command_word_t;

    typedef struct packed {
        logic [ENERGY_BITS-1:0] energy;
        status_t                status;
        logic [COUNT_BITS-1:0]  count;
    } result_word_t;

    // One directed row: the command word and, where typed is set, the result
    // it must give; otherwise the table walker takes the predicted result.
    typedef struct packed {
        command_word_t word;
        bit            typed;
        result_word_t  want;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 24;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        // draw from the empty table straight out of reset
        '{'{CMD_SAMPLE, 24'h000000, 16'h0000, 32'hFFFF_FFFF}, 1'b1,
          '{24'h000000, STAT_EMPTY, 9'd0}},
        // zero energy is rejected, all-ones weight ignored
        '{'{CMD_APPEND, 24'h000000, 16'hFFFF, 32'hFFFF_FFFF}, 1'b1,
          '{24'h000000, STAT_ZERO_ENERGY, 9'd0}},
        // unused code with every field at all ones
        '{'{CMD_UNUSED, 24'hFFFFFF, 16'hFFFF, 32'hFFFF_FFFF}, 1'b1,
          '{24'h000000, STAT_OK, 9'd0}},
        // max energy with zero weight: held, but the table weighs nothing
        '{'{CMD_APPEND, 24'hFFFFFF, 16'h0000, 32'h0000_0000}, 1'b1,
          '{24'h000000, STAT_OK, 9'd1}},
        '{'{CMD_SAMPLE, 24'h000000, 16'h0000, 32'h8000_0000}, 1'b1,
          '{24'h000000, STAT_EMPTY, 9'd1}},
        // smallest energy, largest weight: it takes every draw
        '{'{CMD_APPEND, 24'h000001, 16'hFFFF, 32'h0000_0000}, 1'b1,
          '{24'h000000, STAT_OK, 9'd2}},
        '{'{CMD_SAMPLE, 24'h000000, 16'h0000, 32'h0000_0000}, 1'b1,
          '{24'h000001, STAT_OK, 9'd2}},
        '{'{CMD_SAMPLE, 24'hFFFFFF, 16'hFFFF, 32'hFFFF_FFFF}, 1'b1,
          '{24'h000001, STAT_OK, 9'd2}},
        // clear with noise on the unused fields
        '{'{CMD_CLEAR, 24'hFFFFFF, 16'hFFFF, 32'hFFFF_FFFF}, 1'b1,
          '{24'h000000, STAT_OK, 9'd0}},
        '{'{CMD_SAMPLE, 24'h000000, 16'h0000, 32'h0000_0000}, 1'b1,
          '{24'h000000, STAT_EMPTY, 9'd0}},
        // cumulative weights 1, 1, 4: a zero-weight entry in the middle
        '{'{CMD_APPEND, 24'h000100, 16'h0001, 32'h0000_0000}, 1'b1,
          '{24'h000000, STAT_OK, 9'd1}},
        '{'{CMD_APPEND, 24'h800000, 16'h0000, 32'h0000_0000}, 1'b1,
          '{24'h000000, STAT_OK, 9'd2}},
        '{'{CMD_APPEND, 24'h7FFFFF, 16'h0003, 32'h0000_0000}, 1'b1,
          '{24'h000000, STAT_OK, 9'd3}},
        '{'{CMD_SAMPLE, 24'h000000, 16'h0000, 32'h0000_0000}, 1'b1,
          '{24'h000100, STAT_OK, 9'd3}},
        // target 1 must skip the zero-weight entry
        '{'{CMD_SAMPLE, 24'h000000, 16'h0000, 32'h4000_0000}, 1'b1,
          '{24'h7FFFFF, STAT_OK, 9'd3}},
        '{'{CMD_SAMPLE, 24'h000000, 16'h0000, 32'h3FFF_FFFF}, 1'b0, '0},
        '{'{CMD_SAMPLE, 24'h000000, 16'h0000, 32'hFFFF_FFFF}, 1'b0, '0},
        '{'{CMD_APPEND, 24'hABCDEF, 16'hFFFF, 32'h0000_0000}, 1'b0, '0},
        '{'{CMD_SAMPLE, 24'h000000, 16'h0000, 32'h0001_0000}, 1'b0, '0},
        '{'{CMD_SAMPLE, 24'h000000, 16'h0000, 32'hC000_0000}, 1'b0, '0},
        '{'{CMD_APPEND, 24'h000000, 16'h0005, 32'h0000_0000}, 1'b1,
          '{24'h000000, STAT_ZERO_ENERGY, 9'd4}},
        '{'{CMD_UNUSED, 24'h5A5A5A, 16'hA5A5, 32'h1234_5678}, 1'b1,
          '{24'h000000, STAT_OK, 9'd4}},
        '{'{CMD_SAMPLE, 24'h000000, 16'h0000, 32'h5555_5555}, 1'b0, '0},
        '{'{CMD_CLEAR, 24'h000000, 16'h0000, 32'h0000_0000}, 1'b1,
          '{24'h000000, STAT_OK, 9'd0}}
    };

    logic clk = 1'b0;
    logic rst_n;

    dics_req_if req_ch ();
    dics_rsp_if rsp_ch ();

    discrete_inverse_cdf_sampler_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_ch),
        .result  (rsp_ch)
    );

    // Shadow of the sampler table, advanced once per accepted command word.
    logic [ENERGY_BITS-1:0] tbl_energy [TABLE_DEPTH];
    logic [CUM_BITS-1:0]    tbl_cum    [TABLE_DEPTH];
    int unsigned            tbl_count = 0;
    logic [CUM_BITS-1:0]    tbl_total = '0;

    result_word_t predicted_results [$];

    int src_idle_pct  = 11;
    int snk_idle_pct  = 85;
    bit long_hold_req = 1'b0;
    int error_count   = 0;
    int words_sent    = 0;
    int stall_cycles  = 0;
    int status_tally [4] = '{default: 0};

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one command to the shadow table and return the result word it gives.
    function automatic result_word_t apply_command(command_word_t w);
        result_word_t          r;
        logic [PROD_BITS-1:0]  product;
        logic [CUM_BITS-1:0]   target;
        logic [CUM_BITS:0]     sum;
        int unsigned           lo;
        int unsigned           hi;
        int unsigned           mid;
        r.energy = '0;
        r.status = STAT_OK;
        case (w.cmd)
            CMD_CLEAR:
            begin
                tbl_count = 0;
                tbl_total = '0;
            end
            CMD_APPEND:
            begin
                // zero energy is checked before a full table
                if (w.energy == '0)
                    r.status = STAT_ZERO_ENERGY;
                else if (tbl_count >= TABLE_DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    sum = {1'b0, tbl_total} + (CUM_BITS + 1)'(w.weight);
                    tbl_total = sum[CUM_BITS] ? '1 : sum[CUM_BITS-1:0];
                    tbl_energy[tbl_count] = w.energy;
                    tbl_cum[tbl_count]    = tbl_total;
                    tbl_count++;
                end
            end
            CMD_SAMPLE:
            begin
                if (tbl_count == 0 || tbl_total == '0)
                    r.status = STAT_EMPTY;
                else
                begin
                    product = PROD_BITS'(w.fraction) * PROD_BITS'(tbl_total);
                    target  = product[PROD_BITS-1:RAND_BITS];
                    // first entry whose cumulative weight exceeds the target
                    lo = 0;
                    hi = tbl_count;
                    while (lo < hi)
                    begin
                        mid = lo + (hi - lo) / 2;
                        if (tbl_cum[mid] > target)
                            hi = mid;
                        else
                            lo = mid + 1;
                    end
                    if (lo >= tbl_count)
                        lo = tbl_count - 1;
                    r.energy = tbl_energy[lo];
                end
            end
            default: ;
        endcase
        r.count = COUNT_BITS'(tbl_count);
        return r;
    endfunction

    function automatic logic [ENERGY_BITS-1:0] pick_energy();
        return ENERGY_BITS'($urandom_range(24'hFFFFFF, 1));
    endfunction

    // Favor tiny and zero weights so that cumulative values repeat often.
    function automatic logic [WEIGHT_BITS-1:0] pick_weight();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3:    return WEIGHT_BITS'($urandom_range(3));
            4, 5:    return WEIGHT_BITS'($urandom_range(255));
            default: return WEIGHT_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [RAND_BITS-1:0] pick_fraction();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Offer one word, idling first at the current sender rate; on accept,
    // queue the typed result if given, else the predicted one.
    task automatic send_word(command_word_t w, bit typed, result_word_t want);
        result_word_t predicted;
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid           <= 1'b0;
            req_ch.command         <= 2'($urandom);
            req_ch.energy_code     <= ENERGY_BITS'($urandom);
            req_ch.entry_weight    <= WEIGHT_BITS'($urandom);
            req_ch.random_fraction <= $urandom;
            @(posedge clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.command         <= w.cmd;
        req_ch.energy_code     <= w.energy;
        req_ch.entry_weight    <= w.weight;
        req_ch.random_fraction <= w.fraction;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        predicted = apply_command(w);
        if (typed)
            predicted = want;
        predicted_results = {predicted_results, predicted};
        words_sent++;
    endtask

    task automatic issue(logic [1:0] cmd, logic [ENERGY_BITS-1:0] energy,
                         logic [WEIGHT_BITS-1:0] weight, logic [RAND_BITS-1:0] fraction);
        send_word(command_word_t'{cmd, energy, weight, fraction}, 1'b0, '0);
    endtask

    // Drop valid and hold until every queued result word has come back.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (predicted_results.size() != 0);
    endtask

    // Random episodes: mostly clear, append up to 24 entries and draw from the
    // table; now and then fill the table to the top and push past it.
    task automatic run_random(int budget, bit fill_first);
        int stop_at;
        bit fill;
        int n_app;
        int i;
        int roll;
        stop_at = words_sent + budget;
        fill    = fill_first;
        while (words_sent < stop_at)
        begin
            fill = fill || ($urandom_range(99) < 6);
            if (fill || $urandom_range(99) < 80)
                issue(CMD_CLEAR, ENERGY_BITS'($urandom), WEIGHT_BITS'($urandom), $urandom);
            n_app = fill ? 0 : $urandom_range(24, 1);
            i = 0;
            while (fill ? (tbl_count < TABLE_DEPTH) : (i < n_app))
            begin
                roll = $urandom_range(99);
                if (roll < 6)
                    issue(CMD_APPEND, '0, pick_weight(), $urandom);
                else if (roll < 9)
                    issue(CMD_UNUSED, ENERGY_BITS'($urandom), WEIGHT_BITS'($urandom), $urandom);
                else
                    issue(CMD_APPEND, pick_energy(), pick_weight(), $urandom);
                if ($urandom_range(99) < (fill ? 4 : 30))
                    issue(CMD_SAMPLE, ENERGY_BITS'($urandom), WEIGHT_BITS'($urandom),
                          pick_fraction());
                i++;
            end
            if (fill)
            begin
                // full table: rejected appends, then a zero energy that must win
                repeat ($urandom_range(3, 1))
                    issue(CMD_APPEND, pick_energy(), pick_weight(), $urandom);
                issue(CMD_APPEND, '0, pick_weight(), $urandom);
            end
            repeat ($urandom_range(12, 1))
                issue(CMD_SAMPLE, ENERGY_BITS'($urandom), WEIGHT_BITS'($urandom),
                      pick_fraction());
            fill = 1'b0;
        end
    endtask

    task automatic flag_mismatch(string field, logic [31:0] want, logic [31:0] got);
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
        error_count++;
    endtask

    // Result side: check each accepted word against the oldest prediction,
    // then pick ready for the next cycle. A long hold-off, once requested,
    // is counted here so the request side keeps offering words meanwhile.
    initial
    begin : result_taker
        int           hold_left;
        result_word_t want;
        hold_left    = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                if (predicted_results.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, got %h/%0d/%0d",
                             $time, rsp_ch.sampled_energy, rsp_ch.status,
                             rsp_ch.entry_count);
                    error_count++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    status_tally[want.status]++;
                    if (rsp_ch.sampled_energy !== want.energy)
                        flag_mismatch("sampled_energy", 32'(want.energy),
                                      32'(rsp_ch.sampled_energy));
                    if (rsp_ch.status !== want.status)
                        flag_mismatch("status", 32'(want.status), 32'(rsp_ch.status));
                    if (rsp_ch.entry_count !== want.count)
                        flag_mismatch("entry_count", 32'(want.count),
                                      32'(rsp_ch.entry_count));
                end
            end
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Watchdog: end the run if no word moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin : stimulus_main
        int row;
        rst_n                  = 1'b0;
        req_ch.valid           = 1'b0;
        req_ch.command         = CMD_CLEAR;
        req_ch.energy_code     = '0;
        req_ch.entry_weight    = '0;
        req_ch.random_fraction = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase 1: light sender idling, heavy result-side stalls.
        src_idle_pct = 11;
        snk_idle_pct = 85;
        for (row = 0; row < DIRECTED_ROWS; row++)
            send_word(directed_rows[row].word, directed_rows[row].typed,
                      directed_rows[row].want);
        run_random(WORDS_PER_PHASE - DIRECTED_ROWS, 1'b0);
        wait_drained();

        // Phase 2: the other way round.
        src_idle_pct = 85;
        snk_idle_pct = 11;
        run_random(WORDS_PER_PHASE, 1'b0);
        wait_drained();

        // Phase 3: no idling; open with a long result hold-off so the block
        // backs up and stalls its request side, and fill the table first.
        src_idle_pct  = 0;
        snk_idle_pct  = 0;
        long_hold_req = 1'b1;
        run_random(WORDS_PER_PHASE, 1'b1);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (predicted_results.size() != 0)
        begin
            $display("%0t: %0d result words never arrived", $time, predicted_results.size());
            error_count++;
        end

        $display("Sent %0d command words under three idling mixes,", words_sent);
        $display("with one %0d-cycle result hold-off; results: %0d ok, %0d empty,",
                 LONG_HOLD, status_tally[STAT_OK], status_tally[STAT_EMPTY]);
        $display("%0d table full, %0d zero energy.",
                 status_tally[STAT_FULL], status_tally[STAT_ZERO_ENERGY]);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
